// File: rtl/fcmb_pkg.sv
// ----------------------------------------------------------------------------
// fcmb_pkg: shared definitions for the fixed-capacity multiset bag
// Operation codes, port field widths, parameter defaults and the control
// group that the bag drives into each storage cell.
// ----------------------------------------------------------------------------
package fcmb_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int ITEM_WIDTH_DEF = 32;

    localparam int OP_W     = 3;
    localparam int PORT_W   = 32;
    localparam int COUNT_PW = 5;

    localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
    localparam logic [OP_W-1:0] OP_CONTAINS  = 3'd2;
    localparam logic [OP_W-1:0] OP_FREQUENCY = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;
    localparam logic [OP_W-1:0] OP_LIST      = 3'd5;

    typedef struct packed {
        logic shift_en;
        logic load_en;
    } cell_ctrl_t;

endpackage

// File: rtl/fixed_capacity_multiset_bag.sv
// ----------------------------------------------------------------------------
// fixed_capacity_multiset_bag: fixed-capacity unordered multiset of items
// Entries live in a ring of cells. Searches rotate the ring once past a
// single comparator at the head cell; add writes a cell directly, clear only resets the count.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   s_operation, s_item
//  m_        out        m_valid / m_ready   m_ok, m_frequency, m_listed_item,
//                                           m_listed_valid, m_last,
//                                           m_item_count, m_empty_res
//
//  Add, clear, an unknown code and list of an empty bag skip the scan.
//  Contains, frequency and remove scan one full turn of the ring, and remove
//  of a present item then fixes the slot. List emits one result per stored
//  entry. The ring turns one place per cycle past the head comparator, but
//  holds while a listed entry waits on a full output register and low m_ready.
//  Reset (aresetn low, synchronous) empties the bag; the entries are not cleared.
// ----------------------------------------------------------------------------
module fixed_capacity_multiset_bag import fcmb_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [PORT_W-1:0]   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_ok,
    output logic [COUNT_PW-1:0] m_frequency,
    output logic [PORT_W-1:0]   m_listed_item,
    output logic                m_listed_valid,
    output logic                m_last,
    output logic [COUNT_PW-1:0] m_item_count,
    output logic                m_empty_res
);

    localparam int ENTRY_W = (ITEM_WIDTH < PORT_W) ? ITEM_WIDTH : PORT_W;
    localparam int CNT_W   = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   freq_reg, freq_next;
    logic               ok_reg, ok_next;
    logic [ENTRY_W-1:0] last_reg, last_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [ENTRY_W-1:0] item_reg, item_next;

    logic                m_valid_reg, m_valid_next;
    logic                m_ok_reg;
    logic [COUNT_PW-1:0] m_frequency_reg;
    logic [PORT_W-1:0]   m_listed_item_reg;
    logic                m_listed_valid_reg;
    logic                m_last_reg;
    logic [COUNT_PW-1:0] m_item_count_reg;
    logic                m_empty_res_reg;

    logic               out_load;
    logic               out_ok;
    logic [CNT_W-1:0]   out_freq;
    logic [ENTRY_W-1:0] out_listed;
    logic               out_listed_valid;
    logic               out_last;
    logic               out_free;

    logic [CNT_W+COUNT_PW-1:0] out_freq_wide;
    logic [CNT_W+COUNT_PW-1:0] count_wide;

    logic               accept;
    logic [ENTRY_W-1:0] item_in;
    logic               full;
    logic               add_load;
    logic               fix_load;
    logic               scan_go;
    logic               active;
    logic               hit;
    logic               final_step;
    logic [ENTRY_W-1:0] head;
    logic [ENTRY_W-1:0] cell_data;

    logic [ENTRY_W-1:0] cell_q [CAPACITY];
    cell_ctrl_t         cell_ctrl [CAPACITY];

    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;
    assign item_in    = s_item[ENTRY_W-1:0];
    assign full       = (count_reg == CNT_W'(CAPACITY));
    assign out_free   = !m_valid_reg || m_ready;
    assign head       = cell_q[0];
    assign active     = (step_reg < count_reg);
    assign hit        = active && (head == item_reg);
    assign final_step = (step_reg == CNT_W'(CAPACITY - 1));
    // A list scan holds the ring while a live entry cannot be emitted.
    assign scan_go    = !((op_reg == OP_LIST) && active && !out_free);
    assign cell_data  = (state_reg == S_FIX) ? last_reg : item_reg;

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        step_next        = step_reg;
        idx_next         = idx_reg;
        freq_next        = freq_reg;
        ok_next          = ok_reg;
        last_next        = last_reg;
        op_next          = op_reg;
        item_next        = item_reg;
        add_load         = 1'b0;
        fix_load         = 1'b0;
        out_load         = 1'b0;
        out_ok           = 1'b0;
        out_freq         = '0;
        out_listed       = '0;
        out_listed_valid = 1'b0;
        out_last         = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next    = s_operation;
                    item_next  = item_in;
                    step_next  = '0;
                    ok_next    = 1'b0;
                    freq_next  = '0;
                    state_next = S_RESP;
                    unique case (s_operation) inside
                        OP_ADD: begin
                            if (!full) begin
                                count_next = count_reg + 1'b1;
                                ok_next    = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_REMOVE, OP_CONTAINS, OP_FREQUENCY: begin
                            state_next = S_SCAN;
                        end
                        OP_LIST: begin
                            if (count_reg != '0) begin
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_go) begin
                    step_next = step_reg + 1'b1;
                    if (hit && !ok_reg && op_reg != OP_FREQUENCY) begin
                        ok_next  = 1'b1;
                        idx_next = step_reg;
                    end
                    if (hit && op_reg == OP_FREQUENCY) begin
                        freq_next = freq_reg + 1'b1;
                    end
                    if (active && step_reg == count_reg - 1'b1) begin
                        last_next = head;
                    end
                    if (op_reg == OP_LIST && active) begin
                        out_load         = 1'b1;
                        out_listed       = head;
                        out_listed_valid = 1'b1;
                        out_last         = (step_reg == count_reg - 1'b1);
                    end
                    if (final_step) begin
                        if (op_reg == OP_LIST) begin
                            state_next = S_IDLE;
                        end else if (op_reg == OP_REMOVE && ok_next) begin
                            state_next = S_FIX;
                        end else begin
                            state_next = S_RESP;
                        end
                    end
                end
            end
            S_FIX: begin
                // The last entry fills the slot of the removed one.
                fix_load   = 1'b1;
                count_next = count_reg - 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_ok     = ok_reg;
                    out_freq   = freq_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_IDLE && accept && s_operation == OP_ADD && !full) begin
            add_load = 1'b1;
        end
    end

    genvar j;
    generate
        for (j = 0; j < CAPACITY; j++) begin : g_cell
            always_comb begin
                cell_ctrl[j].shift_en = (state_reg == S_SCAN) && scan_go;
                cell_ctrl[j].load_en  = (add_load && count_reg == CNT_W'(j)) ||
                                        (fix_load && idx_reg == CNT_W'(j));
            end

            fcmb_cell #(
                .ENTRY_W (ENTRY_W)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (cell_ctrl[j]),
                .shift_in  (cell_q[(j + 1) % CAPACITY]),
                .load_data (add_load ? item_in : cell_data),
                .entry_out (cell_q[j])
            );
        end
    endgenerate

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign out_freq_wide = (CNT_W + COUNT_PW)'(out_freq);
    assign count_wide    = (CNT_W + COUNT_PW)'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        idx_reg  <= idx_next;
        freq_reg <= freq_next;
        ok_reg   <= ok_next;
        last_reg <= last_next;
        op_reg   <= op_next;
        item_reg <= item_next;
        if (out_load) begin
            m_ok_reg           <= out_ok;
            m_frequency_reg    <= out_freq_wide[COUNT_PW-1:0];
            m_listed_item_reg  <= PORT_W'(out_listed);
            m_listed_valid_reg <= out_listed_valid;
            m_last_reg         <= out_last;
            m_item_count_reg   <= count_wide[COUNT_PW-1:0];
            m_empty_res_reg    <= (count_next == '0);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_ok           = m_ok_reg;
    assign m_frequency    = m_frequency_reg;
    assign m_listed_item  = m_listed_item_reg;
    assign m_listed_valid = m_listed_valid_reg;
    assign m_last         = m_last_reg;
    assign m_item_count   = m_item_count_reg;
    assign m_empty_res    = m_empty_res_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("stored count exceeds capacity");

    a_fix_found: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FIX |-> ok_reg && count_reg != '0)
        else $error("slot fix without a found entry");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_operation == OP_CLEAR |=> count_reg == '0)
        else $error("clear left entries in the bag");

    a_ring_home: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN && scan_go && final_step |=> state_reg != S_SCAN)
        else $error("scan ran past one full turn of the ring");

endmodule

// File: rtl/fcmb_cell.sv
// ----------------------------------------------------------------------------
// fcmb_cell: one storage cell of the bag ring
// Holds one entry. A load writes new data; otherwise a shift takes the entry
// of the neighbor cell, so the ring rotates one place per cycle while shift is enabled.
// ----------------------------------------------------------------------------
module fcmb_cell import fcmb_pkg::*; #(
    parameter int ENTRY_W = ITEM_WIDTH_DEF
) (
    input  logic               aclk,
    input  cell_ctrl_t         ctrl,
    input  logic [ENTRY_W-1:0] shift_in,
    input  logic [ENTRY_W-1:0] load_data,
    output logic [ENTRY_W-1:0] entry_out
);

    logic [ENTRY_W-1:0] entry_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load_en) begin
            entry_reg <= load_data;
        end else if (ctrl.shift_en) begin
            entry_reg <= shift_in;
        end
    end

    assign entry_out = entry_reg;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for fixed_capacity_multiset_bag
// A queue of requests feeds a valid/ready driver. Each accepted request runs
// through a behavioral copy of the bag that queues the expected results.
// A monitor compares every accepted result against the oldest expected one.
// The run goes through phases with different sender and receiver idling, and
// one phase where the receiver holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
    import fcmb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BAG_DEPTH      = CAPACITY_DEF;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PER_PHASE = 16;

    // Codes past list are unused by the bag and must come back as a plain no-op.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PORT_W-1:0] word;
    } bag_request_t;

    typedef struct packed {
        logic                ok;
        logic [COUNT_PW-1:0] frequency;
        logic [PORT_W-1:0]   listed_item;
        logic                listed_valid;
        logic                last;
        logic [COUNT_PW-1:0] item_count;
        logic                empty_res;
    } bag_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation = '0;
    logic [PORT_W-1:0]   s_item = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_ok;
    logic [COUNT_PW-1:0] m_frequency;
    logic [PORT_W-1:0]   m_listed_item;
    logic                m_listed_valid;
    logic                m_last;
    logic [COUNT_PW-1:0] m_item_count;
    logic                m_empty_res;

    bag_request_t pending_requests[$];
    bag_result_t  awaited_results[$];

    // Shadow copy of the bag contents.
    logic [PORT_W-1:0] shadow_slots[BAG_DEPTH];
    int unsigned       shadow_count = 0;

    logic [PORT_W-1:0] word_pool[4];
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  queued_count   = 0;
    int  accepted_count = 0;
    int  error_count    = 0;
    int  idle_cycles    = 0;
    logic hold_arm  = 1'b0;
    logic hold_done = 1'b0;
    int  hold_left  = 0;

    fixed_capacity_multiset_bag DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_item         (s_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ok           (m_ok),
        .m_frequency    (m_frequency),
        .m_listed_item  (m_listed_item),
        .m_listed_valid (m_listed_valid),
        .m_last         (m_last),
        .m_item_count   (m_item_count),
        .m_empty_res    (m_empty_res)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic flag_error(input string msg);
        error_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [PORT_W-1:0] got,
                               input logic [PORT_W-1:0] want);
        if (got !== want) begin
            flag_error($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    // Applies one request to the shadow bag and queues the results it yields.
    function automatic void bag_apply(input logic [OP_W-1:0] op,
                                      input logic [PORT_W-1:0] word);
        bag_result_t res;
        int first_hit;
        int hit_total;
        res = '0;
        res.last = 1'b1;
        first_hit = -1;
        hit_total = 0;
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_slots[i] == word) begin
                if (first_hit < 0) begin
                    first_hit = i;
                end
                hit_total++;
            end
        end
        case (op)
            OP_ADD: begin
                if (shadow_count < BAG_DEPTH) begin
                    shadow_slots[shadow_count] = word;
                    shadow_count++;
                    res.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                // The last entry fills the hole left by the removed one.
                if (first_hit >= 0) begin
                    shadow_count--;
                    shadow_slots[first_hit] = shadow_slots[shadow_count];
                    res.ok = 1'b1;
                end
            end
            OP_CONTAINS: res.ok = (first_hit >= 0);
            OP_FREQUENCY: res.frequency = COUNT_PW'(hit_total);
            OP_CLEAR: shadow_count = 0;
            default: ;
        endcase
        res.item_count = COUNT_PW'(shadow_count);
        res.empty_res  = (shadow_count == 0);
        if (op == OP_LIST && shadow_count != 0) begin
            for (int i = 0; i < shadow_count; i++) begin
                res.listed_item  = shadow_slots[i];
                res.listed_valid = 1'b1;
                res.last         = (i == shadow_count - 1);
                awaited_results = {awaited_results, res};
            end
        end else begin
            awaited_results = {awaited_results, res};
        end
    endfunction

    task automatic queue_request(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] word);
        bag_request_t req;
        req.op = op;
        req.word = word;
        pending_requests = {pending_requests, req};
        queued_count++;
    endtask

    // Mostly words from a small pool so that removes and searches find matches.
    function automatic logic [PORT_W-1:0] pick_word();
        if ($urandom_range(9) < 7) begin
            return word_pool[$urandom_range(3)];
        end
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 34) return OP_ADD;
        if (r < 54) return OP_REMOVE;
        if (r < 64) return OP_CONTAINS;
        if (r < 74) return OP_FREQUENCY;
        if (r < 80) return OP_CLEAR;
        if (r < 95) return OP_LIST;
        if (r < 97) return OP_SPARE_LO;
        return OP_SPARE_HI;
    endfunction

    task automatic wait_drained();
        while (accepted_count != queued_count || awaited_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Overfills the bag so the full case is always hit, then lists it.
    task automatic queue_fill_burst();
        for (int i = 0; i <= BAG_DEPTH; i++) begin
            queue_request(OP_ADD, pick_word());
        end
        queue_request(OP_LIST, pick_word());
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n_random);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < 4; i++) begin
            word_pool[i] = $urandom;
        end
        queue_request(OP_CLEAR, pick_word());
        queue_fill_burst();
        for (int i = 0; i < n_random; i++) begin
            queue_request(pick_op(), pick_word());
        end
        wait_drained();
    endtask

    // Driver: presents the next request once the current one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin : drive
            bag_request_t req;
            if (s_valid) begin
                bag_apply(s_operation, s_item);
                accepted_count++;
            end
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req = pending_requests.pop_front();
                s_valid     <= 1'b1;
                s_operation <= req.op;
                s_item      <= req.word;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when armed.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin : monitor
            bag_result_t want;
            if (awaited_results.size() == 0) begin
                flag_error("result arrived with nothing outstanding");
            end else begin
                want = awaited_results.pop_front();
                check_field("ok", m_ok, want.ok);
                check_field("frequency", m_frequency, want.frequency);
                check_field("listed_item", m_listed_item, want.listed_item);
                check_field("listed_valid", m_listed_valid, want.listed_valid);
                check_field("last", m_last, want.last);
                check_field("item_count", m_item_count, want.item_count);
                check_field("empty_res", m_empty_res, want.empty_res);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[fixed_capacity_multiset_bag] ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty-bag cases, extreme words, unused codes, duplicates and the
        // move-last-into-hole behavior of remove.
        queue_request(OP_LIST, 32'h0);
        queue_request(OP_REMOVE, 32'h0);
        queue_request(OP_CONTAINS, 32'hFFFF_FFFF);
        queue_request(OP_FREQUENCY, 32'h0);
        queue_request(OP_SPARE_LO, 32'h0);
        queue_request(OP_SPARE_HI, 32'hFFFF_FFFF);
        queue_request(OP_ADD, 32'h0);
        queue_request(OP_ADD, 32'hFFFF_FFFF);
        queue_request(OP_ADD, 32'h0);
        queue_request(OP_ADD, 32'hA5A5_5A5A);
        queue_request(OP_FREQUENCY, 32'h0);
        queue_request(OP_CONTAINS, 32'hFFFF_FFFF);
        queue_request(OP_REMOVE, 32'h0);
        queue_request(OP_LIST, 32'h0);
        queue_request(OP_REMOVE, 32'h1234_5678);
        queue_request(OP_CLEAR, 32'hFFFF_FFFF);
        queue_request(OP_LIST, 32'h0);
        queue_request(OP_CONTAINS, 32'h0);
        wait_drained();

        run_phase(0, 0, RANDOM_PER_PHASE);
        run_phase(67, 0, RANDOM_PER_PHASE);
        run_phase(0, 67, RANDOM_PER_PHASE);
        run_phase(18, 18, RANDOM_PER_PHASE);

        // The receiver goes quiet while requests keep coming, so the bag backs up.
        hold_arm = 1'b1;
        run_phase(0, 0, 2);

        repeat (BAG_DEPTH + 8) @(negedge aclk);
        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("[fixed_capacity_multiset_bag] OK");
        end else begin
            $display("[fixed_capacity_multiset_bag] ERROR");
        end
        $finish;
    end

endmodule
